// ===== design/sigma_size_band_filter_unit_defines.svh =====
// Assertion macros shared by the sigma size band filter modules
`ifndef SIGMA_SIZE_BAND_FILTER_UNIT_DEFINES_SVH
`define SIGMA_SIZE_BAND_FILTER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SSBF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
`define SSBF_ASSERT_IMP(lbl, ante, cons) `SSBF_ASSERT(lbl, (ante) |-> (cons))
`else
`define SSBF_ASSERT(lbl, prop)
`define SSBF_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== design/ssbf_pkg.sv =====
// Types and constants of the sigma size band filter
`timescale 1ns / 1ps

package ssbf_pkg;

    localparam int DIM_BITS   = 12;
    localparam int LABEL_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int TOL_W      = 4;
    localparam int BOUND_W    = 25;
    localparam int REQ_W      = 2;
    localparam int MEAN_W     = DIM_BITS + FRAC_BITS;

    localparam logic [TOL_W-1:0] TOL_RESET = 4'd6;

    localparam logic [REQ_W-1:0] REQ_SEED = 2'd0;
    localparam logic [REQ_W-1:0] REQ_PASS = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CAND = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NOP  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_OUTSIDE  = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NO_BANDS = 3'd5
    } status_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        logic    walk_sum;
        logic    walk_ss;
        logic    walk_dup;
        logic    div_start;
        logic    sel_mean;
        logic    sel_h;
        logic    sq_start;
        logic    bands;
        logic    append;
        logic    finish;
        logic    accept;
        status_t status;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             bands_valid;
        logic             full;
        logic             empty;
        logic             dup;
        logic             in_band;
        logic             div_done;
        logic             sq_done;
    } sts_t;

endpackage

// ===== design/ssbf_ram.sv =====
// Generic single-write RAM with registered read
`timescale 1ns / 1ps

module ssbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ssbf_div.sv =====
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`include "sigma_size_band_filter_unit_defines.svh"

module ssbf_div #(
    parameter int DVD_W = 48,
    parameter int DVS_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DVD_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    `SSBF_ASSERT_IMP(a_div_start_idle, start, !busy_reg)

endmodule

// ===== design/ssbf_dp.sv =====
// Datapath: entry table, accumulators, divider, square root, bands, result registers
`timescale 1ns / 1ps
`include "sigma_size_band_filter_unit_defines.svh"

module ssbf_dp #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ssbf_pkg::cmd_t                        cmd,
    input  logic [$clog2(MAX_ENTRIES)-1:0]        rd_addr,
    output ssbf_pkg::sts_t                        sts,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]      count,
    input  logic [ssbf_pkg::REQ_W-1:0]            req_type,
    input  logic [ssbf_pkg::LABEL_BITS-1:0]       label,
    input  logic [ssbf_pkg::DIM_BITS-1:0]         box_width,
    input  logic [ssbf_pkg::DIM_BITS-1:0]         box_height,
    input  logic                                  cfg_valid,
    input  logic [ssbf_pkg::TOL_W-1:0]            cfg_data,
    output logic                                  done,
    output logic                                  accepted,
    output logic [2:0]                            status,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]      stored_count,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   lower_width,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   upper_width,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   lower_height,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   upper_height
);

    localparam int ADDR_W  = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int DIM_W   = ssbf_pkg::DIM_BITS;
    localparam int FRAC_W  = ssbf_pkg::FRAC_BITS;
    localparam int MEAN_W  = ssbf_pkg::MEAN_W;
    localparam int SUM_W   = DIM_W + ADDR_W;
    localparam int SQ_W    = 2 * MEAN_W;
    localparam int SS_W    = SQ_W + ADDR_W;
    localparam int RT_W    = (SS_W + 1) / 2;
    localparam int RC_W    = $clog2(RT_W + 1);
    localparam int SD_W    = RT_W + ssbf_pkg::TOL_W;
    localparam int BW      = SD_W + 2;
    localparam int BOUND_W = ssbf_pkg::BOUND_W;
    localparam logic signed [BW-1:0] BMAX = BW'((64'd1 << (BOUND_W - 1)) - 64'd1);
    localparam logic signed [BW-1:0] BMIN = -BMAX;

    logic [ssbf_pkg::REQ_W-1:0]      req_reg;
    logic [ssbf_pkg::LABEL_BITS-1:0] lab_reg;
    logic [DIM_W-1:0]                w_reg, h_reg;
    logic [CNT_W-1:0]                count_reg;
    logic [ssbf_pkg::TOL_W-1:0]      tol_reg;
    logic                            bv_reg;
    logic                            v1_reg, v2_reg, v3_reg;
    logic                            dup_reg;
    logic [SUM_W-1:0]                sumw_reg, sumh_reg;
    logic [MEAN_W-1:0]               dw_reg, dh_reg;
    logic [SQ_W-1:0]                 qw_reg, qh_reg;
    logic [SS_W-1:0]                 ssw_reg, ssh_reg;
    logic [MEAN_W-1:0]               meanw_reg, meanh_reg;
    logic [SS_W-1:0]                 varw_reg, varh_reg;
    logic [RT_W-1:0]                 rootw_reg, rooth_reg;
    logic signed [BOUND_W-1:0]       lw_reg, uw_reg, lh_reg, uh_reg;
    logic                            done_reg, acc_reg;
    ssbf_pkg::status_t               status_reg;

    logic [2*RT_W-1:0]               sqv_reg, sqv_next;
    logic [RT_W+1:0]                 sqr_reg, sqr_next;
    logic [RT_W-1:0]                 sqo_reg, sqo_next;
    logic [RC_W-1:0]                 sqc_reg, sqc_next;
    logic                            sqb_reg, sqb_next;
    logic                            sqd_reg, sqd_next;
    logic [RT_W+3:0]                 rem_sh, trial;

    logic [ssbf_pkg::LABEL_BITS-1:0] rd_lab;
    logic [2*DIM_W-1:0]              rd_dim;
    logic [DIM_W-1:0]                rd_w, rd_h;
    logic signed [MEAN_W:0]          diffw, diffh;
    logic [SUM_W+FRAC_W-1:0]         scaled_sum;
    logic [SS_W-1:0]                 dividend;
    logic [CNT_W-1:0]                divisor;
    logic [SS_W-1:0]                 quotient;
    logic                            div_done;
    logic                            full, empty, n_one;
    logic [SD_W-1:0]                 sdw, sdh;
    logic signed [BW-1:0]            lw_raw, uw_raw, lh_raw, uh_raw;
    logic signed [BOUND_W-1:0]       sw, sh;
    logic                            in_band;

    function automatic logic signed [BOUND_W-1:0] sat_bound(input logic signed [BW-1:0] v);
        logic signed [BW-1:0] r;
        if (v > BMAX)
        begin
            r = BMAX;
        end
        else if (v < BMIN)
        begin
            r = BMIN;
        end
        else
        begin
            r = v;
        end
        return r[BOUND_W-1:0];
    endfunction

    ssbf_ram #(.WIDTH(ssbf_pkg::LABEL_BITS), .DEPTH(MAX_ENTRIES)) u_lab_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (lab_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_lab)
    );

    ssbf_ram #(.WIDTH(2 * DIM_W), .DEPTH(MAX_ENTRIES)) u_dim_ram (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata ({w_reg, h_reg}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_dim)
    );

    ssbf_div #(.DVD_W(SS_W), .DVS_W(CNT_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        rd_w       = rd_dim[2*DIM_W-1:DIM_W];
        rd_h       = rd_dim[DIM_W-1:0];
        diffw      = $signed({1'b0, MEAN_W'(rd_w) << FRAC_W}) - $signed({1'b0, meanw_reg});
        diffh      = $signed({1'b0, MEAN_W'(rd_h) << FRAC_W}) - $signed({1'b0, meanh_reg});
        full       = (count_reg == CNT_W'(MAX_ENTRIES));
        empty      = (count_reg == '0);
        n_one      = (count_reg == CNT_W'(1));
        scaled_sum = cmd.sel_h ? {sumh_reg, {FRAC_W{1'b0}}} : {sumw_reg, {FRAC_W{1'b0}}};
        if (cmd.sel_mean)
        begin
            dividend = SS_W'(scaled_sum);
            divisor  = count_reg;
        end
        else
        begin
            dividend = cmd.sel_h ? ssh_reg : ssw_reg;
            divisor  = count_reg - 1'b1;
        end
        sdw     = rootw_reg * tol_reg;
        sdh     = rooth_reg * tol_reg;
        lw_raw  = $signed(BW'(meanw_reg)) - $signed(BW'(sdw));
        uw_raw  = $signed(BW'(meanw_reg)) + $signed(BW'(sdw));
        lh_raw  = $signed(BW'(meanh_reg)) - $signed(BW'(sdh));
        uh_raw  = $signed(BW'(meanh_reg)) + $signed(BW'(sdh));
        sw      = $signed(BOUND_W'(MEAN_W'(w_reg) << FRAC_W));
        sh      = $signed(BOUND_W'(MEAN_W'(h_reg) << FRAC_W));
        in_band = (sw >= lw_reg) && (sw <= uw_reg) && (sh >= lh_reg) && (sh <= uh_reg);
    end

    // digit-by-digit square root, two radicand bits per cycle
    always_comb
    begin
        rem_sh   = {sqr_reg, sqv_reg[2*RT_W-1 -: 2]};
        trial    = (RT_W + 4)'({sqo_reg, 2'b01});
        sqv_next = sqv_reg;
        sqr_next = sqr_reg;
        sqo_next = sqo_reg;
        sqc_next = sqc_reg;
        sqb_next = sqb_reg;
        sqd_next = 1'b0;
        if (cmd.sq_start)
        begin
            sqv_next = (2 * RT_W)'(cmd.sel_h ? varh_reg : varw_reg);
            sqr_next = '0;
            sqo_next = '0;
            sqc_next = '0;
            sqb_next = 1'b1;
        end
        else if (sqb_reg)
        begin
            sqv_next = sqv_reg << 2;
            if (rem_sh >= trial)
            begin
                sqr_next = (RT_W + 2)'(rem_sh - trial);
                sqo_next = {sqo_reg[RT_W-2:0], 1'b1};
            end
            else
            begin
                sqr_next = rem_sh[RT_W+1:0];
                sqo_next = {sqo_reg[RT_W-2:0], 1'b0};
            end
            sqc_next = sqc_reg + 1'b1;
            if (sqc_reg == RC_W'(RT_W - 1))
            begin
                sqb_next = 1'b0;
                sqd_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            tol_reg    <= ssbf_pkg::TOL_RESET;
            bv_reg     <= 1'b0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            lw_reg     <= '0;
            uw_reg     <= '0;
            lh_reg     <= '0;
            uh_reg     <= '0;
            done_reg   <= 1'b0;
            sqb_reg    <= 1'b0;
            sqd_reg    <= 1'b0;
            sqc_reg    <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tol_reg <= cfg_data;
            end
            if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
            end
            v1_reg   <= cmd.rd_en;
            v2_reg   <= v1_reg & cmd.walk_ss;
            v3_reg   <= v2_reg;
            done_reg <= cmd.finish;
            sqb_reg  <= sqb_next;
            sqd_reg  <= sqd_next;
            sqc_reg  <= sqc_next;
            if (cmd.bands)
            begin
                lw_reg <= sat_bound(lw_raw);
                uw_reg <= sat_bound(uw_raw);
                lh_reg <= sat_bound(lh_raw);
                uh_reg <= sat_bound(uh_raw);
                bv_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sqv_reg <= sqv_next;
        sqr_reg <= sqr_next;
        sqo_reg <= sqo_next;
        if (cmd.load)
        begin
            req_reg  <= req_type;
            lab_reg  <= label;
            w_reg    <= box_width;
            h_reg    <= box_height;
            dup_reg  <= 1'b0;
            sumw_reg <= '0;
            sumh_reg <= '0;
            ssw_reg  <= '0;
            ssh_reg  <= '0;
        end
        else
        begin
            if (v1_reg && cmd.walk_dup && (rd_lab == lab_reg))
            begin
                dup_reg <= 1'b1;
            end
            if (v1_reg && cmd.walk_sum)
            begin
                sumw_reg <= sumw_reg + SUM_W'(rd_w);
                sumh_reg <= sumh_reg + SUM_W'(rd_h);
            end
            if (v3_reg)
            begin
                ssw_reg <= ssw_reg + SS_W'(qw_reg);
                ssh_reg <= ssh_reg + SS_W'(qh_reg);
            end
        end
        dw_reg <= diffw[MEAN_W] ? MEAN_W'(-diffw) : diffw[MEAN_W-1:0];
        dh_reg <= diffh[MEAN_W] ? MEAN_W'(-diffh) : diffh[MEAN_W-1:0];
        qw_reg <= dw_reg * dw_reg;
        qh_reg <= dh_reg * dh_reg;
        if (div_done)
        begin
            if (cmd.sel_mean)
            begin
                if (cmd.sel_h)
                begin
                    meanh_reg <= quotient[MEAN_W-1:0];
                end
                else
                begin
                    meanw_reg <= quotient[MEAN_W-1:0];
                end
            end
            else if (cmd.sel_h)
            begin
                varh_reg <= n_one ? '0 : quotient;
            end
            else
            begin
                varw_reg <= n_one ? '0 : quotient;
            end
        end
        if (sqd_reg)
        begin
            if (cmd.sel_h)
            begin
                rooth_reg <= sqo_reg;
            end
            else
            begin
                rootw_reg <= sqo_reg;
            end
        end
        if (cmd.finish)
        begin
            acc_reg    <= cmd.accept;
            status_reg <= cmd.status;
        end
    end

    always_comb
    begin
        sts.req         = req_reg;
        sts.bands_valid = bv_reg;
        sts.full        = full;
        sts.empty       = empty;
        sts.dup         = dup_reg;
        sts.in_band     = in_band;
        sts.div_done    = div_done;
        sts.sq_done     = sqd_reg;
    end

    assign count        = count_reg;
    assign done         = done_reg;
    assign accepted     = acc_reg;
    assign status       = status_reg;
    assign stored_count = count_reg;
    assign lower_width  = lw_reg;
    assign upper_width  = uw_reg;
    assign lower_height = lh_reg;
    assign upper_height = uh_reg;

    `SSBF_ASSERT(a_count_max, count_reg <= CNT_W'(MAX_ENTRIES))
    `SSBF_ASSERT_IMP(a_sq_start_idle, cmd.sq_start, !sqb_reg)

endmodule

// ===== design/ssbf_ctrl.sv =====
// Controller: sequences seeds, start passes and candidate checks
`timescale 1ns / 1ps
`include "sigma_size_band_filter_unit_defines.svh"

module ssbf_ctrl #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ssbf_pkg::sts_t                     sts,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]   count,
    output ssbf_pkg::cmd_t                     cmd,
    output logic [$clog2(MAX_ENTRIES)-1:0]     rd_addr
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = CNT_W + 1;
    localparam int TAIL   = 2;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_DECODE = 13'b0000000000010,
        S_DUP    = 13'b0000000000100,
        S_CHECK  = 13'b0000000001000,
        S_SUM    = 13'b0000000010000,
        S_MEANW  = 13'b0000000100000,
        S_MEANH  = 13'b0000001000000,
        S_SS     = 13'b0000010000000,
        S_VARW   = 13'b0000100000000,
        S_VARH   = 13'b0001000000000,
        S_SQW    = 13'b0010000000000,
        S_SQH    = 13'b0100000000000,
        S_BANDS  = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             go_reg, go_next;
    logic             walk_end;

    always_comb
    begin
        cmd        = '0;
        cmd.status = ssbf_pkg::ST_OK;
        state_next = state_reg;
        walk_end   = (idx_reg == IDX_W'(count) + IDX_W'(TAIL));
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_IDLE;
                cmd.finish = 1'b1;
                unique case (sts.req)
                    ssbf_pkg::REQ_SEED:
                    begin
                        if (sts.full)
                        begin
                            cmd.status = ssbf_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                            cmd.accept = 1'b1;
                        end
                    end
                    ssbf_pkg::REQ_PASS:
                    begin
                        if (sts.empty)
                        begin
                            cmd.status = ssbf_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            cmd.finish = 1'b0;
                            state_next = S_SUM;
                        end
                    end
                    ssbf_pkg::REQ_CAND:
                    begin
                        if (!sts.bands_valid)
                        begin
                            cmd.status = ssbf_pkg::ST_NO_BANDS;
                        end
                        else
                        begin
                            cmd.finish = 1'b0;
                            state_next = S_DUP;
                        end
                    end
                    default:
                    begin
                        cmd.status = ssbf_pkg::ST_OK;
                    end
                endcase
            end
            S_DUP:
            begin
                cmd.walk_dup = 1'b1;
                cmd.rd_en    = (idx_reg < IDX_W'(count));
                if (walk_end)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
                if (sts.dup)
                begin
                    cmd.status = ssbf_pkg::ST_DUP;
                end
                else if (!sts.in_band)
                begin
                    cmd.status = ssbf_pkg::ST_OUTSIDE;
                end
                else if (sts.full)
                begin
                    cmd.status = ssbf_pkg::ST_FULL;
                end
                else
                begin
                    cmd.append = 1'b1;
                    cmd.accept = 1'b1;
                end
            end
            S_SUM:
            begin
                cmd.walk_sum = 1'b1;
                cmd.rd_en    = (idx_reg < IDX_W'(count));
                if (walk_end)
                begin
                    state_next = S_MEANW;
                end
            end
            S_MEANW:
            begin
                cmd.sel_mean  = 1'b1;
                cmd.div_start = go_reg;
                if (sts.div_done)
                begin
                    state_next = S_MEANH;
                end
            end
            S_MEANH:
            begin
                cmd.sel_mean  = 1'b1;
                cmd.sel_h     = 1'b1;
                cmd.div_start = go_reg;
                if (sts.div_done)
                begin
                    state_next = S_SS;
                end
            end
            S_SS:
            begin
                cmd.walk_ss = 1'b1;
                cmd.rd_en   = (idx_reg < IDX_W'(count));
                if (walk_end)
                begin
                    state_next = S_VARW;
                end
            end
            S_VARW:
            begin
                cmd.div_start = go_reg;
                if (sts.div_done)
                begin
                    state_next = S_VARH;
                end
            end
            S_VARH:
            begin
                cmd.sel_h     = 1'b1;
                cmd.div_start = go_reg;
                if (sts.div_done)
                begin
                    state_next = S_SQW;
                end
            end
            S_SQW:
            begin
                cmd.sq_start = go_reg;
                if (sts.sq_done)
                begin
                    state_next = S_SQH;
                end
            end
            S_SQH:
            begin
                cmd.sel_h    = 1'b1;
                cmd.sq_start = go_reg;
                if (sts.sq_done)
                begin
                    state_next = S_BANDS;
                end
            end
            S_BANDS:
            begin
                cmd.bands  = 1'b1;
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        idx_next = (state_next != state_reg) ? '0 : idx_reg + 1'b1;
        go_next  = (state_next != state_reg) &&
                   ((state_next == S_MEANW) || (state_next == S_MEANH) ||
                    (state_next == S_VARW) || (state_next == S_VARH) ||
                    (state_next == S_SQW) || (state_next == S_SQH));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            go_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            go_reg    <= go_next;
        end
    end

    assign busy    = (state_reg != S_IDLE);
    assign rd_addr = idx_reg[ADDR_W-1:0];

    `SSBF_ASSERT_IMP(a_append_room, cmd.append, !sts.full)
    `SSBF_ASSERT(a_finish_idle, cmd.finish |=> state_reg == S_IDLE)
    `SSBF_ASSERT(a_accept_decode, (start && !busy) |=> state_reg == S_DECODE)

endmodule

// ===== design/sigma_size_band_filter_unit.sv =====
// Top level of the sigma size band filter
// Seed, no-op and early-reject words finish in the decode state; then the next start is taken.
// Candidate: a label walk through the table RAM (one read a cycle), then the check state.
// Start pass: two table walks, four divisions on the shared divider, two square roots.
// One word at a time; done pulses in the first idle cycle.
// Reset clears the table count, bands and tolerance (to 6) at once; table contents are kept.
`timescale 1ns / 1ps

module sigma_size_band_filter_unit #(
    parameter int MAX_ENTRIES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [ssbf_pkg::REQ_W-1:0]            req_type,
    input  logic [ssbf_pkg::LABEL_BITS-1:0]       label,
    input  logic [ssbf_pkg::DIM_BITS-1:0]         box_width,
    input  logic [ssbf_pkg::DIM_BITS-1:0]         box_height,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ssbf_pkg::TOL_W-1:0]            cfg_data,
    output logic                                  done,
    output logic                                  accepted,
    output logic [2:0]                            status,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]      stored_count,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   lower_width,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   upper_width,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   lower_height,
    output logic signed [ssbf_pkg::BOUND_W-1:0]   upper_height
);

    ssbf_pkg::cmd_t                    cmd;
    ssbf_pkg::sts_t                    sts;
    logic [$clog2(MAX_ENTRIES+1)-1:0]  count;
    logic [$clog2(MAX_ENTRIES)-1:0]    rd_addr;

    assign cfg_ready = 1'b1;

    ssbf_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .sts     (sts),
        .count   (count),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    ssbf_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .sts          (sts),
        .count        (count),
        .req_type     (req_type),
        .label        (label),
        .box_width    (box_width),
        .box_height   (box_height),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .done         (done),
        .accepted     (accepted),
        .status       (status),
        .stored_count (stored_count),
        .lower_width  (lower_width),
        .upper_width  (upper_width),
        .lower_height (lower_height),
        .upper_height (upper_height)
    );

endmodule

// ===== tb/tb.sv =====
// Testbench for sigma_size_band_filter_unit: queued words, in-order predictor, result checks
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH      = 256;
    localparam int WD_LIMIT   = 6000;
    localparam int REQ_W      = ssbf_pkg::REQ_W;
    localparam int LABEL_BITS = ssbf_pkg::LABEL_BITS;
    localparam int DIM_BITS   = ssbf_pkg::DIM_BITS;
    localparam int FRAC_BITS  = ssbf_pkg::FRAC_BITS;
    localparam int TOL_W      = ssbf_pkg::TOL_W;
    localparam int BOUND_W    = ssbf_pkg::BOUND_W;
    localparam longint BMAX   = 64'sd16777215;

    typedef struct {
        logic [REQ_W-1:0]      req;
        logic [LABEL_BITS-1:0] lab;
        logic [DIM_BITS-1:0]   w;
        logic [DIM_BITS-1:0]   h;
    } word_t;

    typedef struct {
        logic               acc;
        ssbf_pkg::status_t  st;
        logic [8:0]         cnt;
        logic [BOUND_W-1:0] b [4];
    } outcome_t;

    logic clk, rst_n, start, busy, cfg_valid, cfg_ready, done, accepted;
    logic [REQ_W-1:0] req_type;
    logic [LABEL_BITS-1:0] label;
    logic [DIM_BITS-1:0] box_width, box_height;
    logic [TOL_W-1:0] cfg_data;
    logic [2:0] status;
    logic [8:0] stored_count;
    logic signed [BOUND_W-1:0] lower_width, upper_width, lower_height, upper_height;

    sigma_size_band_filter_unit dut (.*);

    // predictor state
    logic [LABEL_BITS-1:0] tab_lab [DEPTH];
    int unsigned tab_w [DEPTH];
    int unsigned tab_h [DEPTH];
    int unsigned n_stored;
    longint bound [4];
    bit have_bands;
    int unsigned tol;

    word_t pend_q[$];
    outcome_t result_q[$];
    int errors, gap, wd;
    bit gaps_on;

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    function automatic longint clip_bound(longint v);
        if (v > BMAX) return BMAX;
        if (v < -BMAX) return -BMAX;
        return v;
    endfunction

    function automatic void column_band(bit use_h, output longint lo, output longint hi);
        longint unsigned sum, ss, v, r, t;
        longint mean, d, sd;
        sum = 0;
        ss = 0;
        for (int i = 0; i < n_stored; i++)
            sum += 64'(use_h ? tab_h[i] : tab_w[i]);
        mean = longint'((sum << FRAC_BITS) / 64'(n_stored));
        for (int i = 0; i < n_stored; i++)
        begin
            d = (longint'(use_h ? tab_h[i] : tab_w[i]) << FRAC_BITS) - mean;
            ss += d * d;
        end
        v = (n_stored >= 2) ? ss / 64'(n_stored - 1) : 64'd0;
        r = 0;
        for (int k = 31; k >= 0; k--)
        begin
            t = r | (64'd1 << k);
            if (t * t <= v) r = t;
        end
        sd = longint'(r) * longint'(tol);
        lo = clip_bound(mean - sd);
        hi = clip_bound(mean + sd);
    endfunction

    function automatic bit size_inside(int unsigned s, longint lo, longint hi);
        longint v;
        v = longint'(s) << FRAC_BITS;
        return v >= lo && v <= hi;
    endfunction

    function automatic bit label_known(logic [LABEL_BITS-1:0] l);
        for (int i = 0; i < n_stored; i++)
            if (tab_lab[i] == l) return 1'b1;
        return 1'b0;
    endfunction

    // predict the outcome of one word and queue it for the driver
    function automatic void push_word(logic [REQ_W-1:0] rq, logic [LABEL_BITS-1:0] l,
                                      logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
        outcome_t o;
        word_t wd_item;
        o.acc = 1'b0;
        o.st = ssbf_pkg::ST_OK;
        if (rq == ssbf_pkg::REQ_SEED)
        begin
            if (n_stored >= DEPTH) o.st = ssbf_pkg::ST_FULL;
            else o.acc = 1'b1;
        end
        else if (rq == ssbf_pkg::REQ_PASS)
        begin
            if (n_stored == 0) o.st = ssbf_pkg::ST_EMPTY;
            else
            begin
                column_band(1'b0, bound[0], bound[1]);
                column_band(1'b1, bound[2], bound[3]);
                have_bands = 1'b1;
            end
        end
        else if (rq == ssbf_pkg::REQ_CAND)
        begin
            if (!have_bands) o.st = ssbf_pkg::ST_NO_BANDS;
            else if (label_known(l)) o.st = ssbf_pkg::ST_DUP;
            else if (!size_inside(32'(w), bound[0], bound[1]) ||
                     !size_inside(32'(h), bound[2], bound[3]))
                o.st = ssbf_pkg::ST_OUTSIDE;
            else if (n_stored >= DEPTH) o.st = ssbf_pkg::ST_FULL;
            else o.acc = 1'b1;
        end
        if (o.acc)
        begin
            tab_lab[n_stored] = l;
            tab_w[n_stored] = 32'(w);
            tab_h[n_stored] = 32'(h);
            n_stored++;
        end
        o.cnt = n_stored[8:0];
        for (int k = 0; k < 4; k++) o.b[k] = bound[k][BOUND_W-1:0];
        wd_item.req = rq;
        wd_item.lab = l;
        wd_item.w = w;
        wd_item.h = h;
        pend_q.insert(pend_q.size(), wd_item);
        result_q.insert(result_q.size(), o);
    endfunction

    function automatic int unsigned pick_inside(longint lo, longint hi);
        longint a, b;
        a = (lo + 255) >>> FRAC_BITS;
        b = hi >>> FRAC_BITS;
        if (a < 0) a = 0;
        if (b > 4095) b = 4095;
        if (a > b) return $urandom_range(4095, 0);
        return $urandom_range(int'(b), int'(a));
    endfunction

    function automatic void random_word();
        int unsigned sel, base;
        logic [LABEL_BITS-1:0] l;
        sel = $urandom_range(99, 0);
        l = LABEL_BITS'($urandom);
        if (sel < 4)
            push_word(ssbf_pkg::REQ_NOP, l, DIM_BITS'($urandom), DIM_BITS'($urandom));
        else if (sel < 12)
            push_word(ssbf_pkg::REQ_PASS, l, DIM_BITS'($urandom), DIM_BITS'($urandom));
        else if (sel < 40)
        begin
            base = $urandom_range(3900, 100);
            if ($urandom_range(3, 0) == 0 && n_stored > 0)
                l = tab_lab[$urandom_range(n_stored - 1, 0)];
            if ($urandom_range(4, 0) == 0)
                push_word(ssbf_pkg::REQ_SEED, l, DIM_BITS'($urandom), DIM_BITS'($urandom));
            else
                push_word(ssbf_pkg::REQ_SEED, l,
                          DIM_BITS'(base % 200 + 1000 + $urandom_range(60, 0)),
                          DIM_BITS'(base % 150 + 500 + $urandom_range(40, 0)));
        end
        else
        begin
            sel = $urandom_range(9, 0);
            if (sel < 2 && n_stored > 0)
                l = tab_lab[$urandom_range(n_stored - 1, 0)];
            if (sel < 7)
                push_word(ssbf_pkg::REQ_CAND, l, DIM_BITS'(pick_inside(bound[0], bound[1])),
                          DIM_BITS'(pick_inside(bound[2], bound[3])));
            else
                push_word(ssbf_pkg::REQ_CAND, l, DIM_BITS'($urandom), DIM_BITS'($urandom));
        end
    endfunction

    task automatic wait_idle();
        while (pend_q.size() != 0 || result_q.size() != 0 || start) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_tol(logic [TOL_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol = 32'(v);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req_type <= ssbf_pkg::REQ_NOP;
            label <= '0;
            box_width <= '0;
            box_height <= '0;
            gap = 0;
        end
        else if (!(start && busy))
        begin
            if (gap > 0)
            begin
                gap--;
                start <= 1'b0;
            end
            else if (pend_q.size() != 0)
            begin
                word_t it;
                it = pend_q.pop_front();
                req_type <= it.req;
                label <= it.lab;
                box_width <= it.w;
                box_height <= it.h;
                start <= 1'b1;
                if (gaps_on && $urandom_range(5, 0) == 0) gap = $urandom_range(5, 1);
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done) wd = 0;
            else wd++;
            if (wd >= WD_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            if (done)
            begin
                if (result_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result word");
                end
                else
                begin
                    outcome_t e;
                    e = result_q.pop_front();
                    if (accepted !== e.acc || status !== e.st || stored_count !== e.cnt ||
                        lower_width !== e.b[0] || upper_width !== e.b[1] ||
                        lower_height !== e.b[2] || upper_height !== e.b[3])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch exp %0d %0d %0d %h %h %h %h",
                                      " got %0d %0d %0d %h %h %h %h"},
                                e.acc, e.st, e.cnt, e.b[0], e.b[1], e.b[2], e.b[3],
                                accepted, status, stored_count,
                                lower_width, upper_width, lower_height, upper_height);
                    end
                end
            end
        end
    end

    initial
    begin
        int unsigned tols [6] = '{0, 15, 3, 6, 1, 9};
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        errors = 0;
        wd = 0;
        gaps_on = 1'b1;
        n_stored = 0;
        have_bands = 1'b0;
        tol = 32'(ssbf_pkg::TOL_RESET);
        for (int k = 0; k < 4; k++) bound[k] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words
        push_word(ssbf_pkg::REQ_NOP, 16'hffff, 12'hfff, 12'hfff);
        push_word(ssbf_pkg::REQ_CAND, 16'h0001, 12'd10, 12'd10);
        push_word(ssbf_pkg::REQ_PASS, 16'h0000, 12'd0, 12'd0);
        push_word(ssbf_pkg::REQ_SEED, 16'h0000, 12'd0, 12'd0);
        push_word(ssbf_pkg::REQ_PASS, 16'h0000, 12'd0, 12'd0);
        push_word(ssbf_pkg::REQ_CAND, 16'h0002, 12'd0, 12'd0);
        push_word(ssbf_pkg::REQ_SEED, 16'hffff, 12'hfff, 12'hfff);
        push_word(ssbf_pkg::REQ_SEED, 16'hffff, 12'd2048, 12'd100);
        push_word(ssbf_pkg::REQ_SEED, 16'h1234, 12'd2000, 12'd90);
        push_word(ssbf_pkg::REQ_PASS, 16'h0000, 12'd0, 12'd0);
        push_word(ssbf_pkg::REQ_CAND, 16'h1234, 12'd2000, 12'd100);
        push_word(ssbf_pkg::REQ_CAND, 16'h5555, 12'd0, 12'd100);
        push_word(ssbf_pkg::REQ_CAND, 16'haaaa, 12'd2000, 12'hfff);
        push_word(ssbf_pkg::REQ_CAND, 16'h7777, 12'd2000, 12'd500);
        write_tol(4'd0);
        push_word(ssbf_pkg::REQ_PASS, 16'h0000, 12'd0, 12'd0);
        push_word(ssbf_pkg::REQ_CAND, 16'h4321, 12'd2000, 12'd500);
        push_word(ssbf_pkg::REQ_CAND, 16'h4322, DIM_BITS'(pick_inside(bound[0], bound[1])),
                  DIM_BITS'(pick_inside(bound[2], bound[3])));
        write_tol(4'd15);
        push_word(ssbf_pkg::REQ_PASS, 16'h0000, 12'd0, 12'd0);
        push_word(ssbf_pkg::REQ_CAND, 16'h8888, 12'd0, 12'd0);

        for (int p = 0; p < 6; p++)
        begin
            write_tol(tols[p][TOL_W-1:0]);
            if (p == 5) gaps_on = 1'b0;
            for (int i = 0; i < 250; i++) random_word();
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0 && result_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// ===== sigma_size_band_filter_unit.f =====
+incdir+design
design/ssbf_pkg.sv
design/ssbf_ram.sv
design/ssbf_div.sv
design/ssbf_dp.sv
design/ssbf_ctrl.sv
design/sigma_size_band_filter_unit.sv
tb/tb.sv
